// ----- design/lew_pkg.sv -----
`default_nettype none
package lew_pkg;

  // Character codes
  localparam logic [7:0] CH_FLUSH = 8'h21;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Width of a fill count carried between front and back (covers buffer depths up to 64)
  localparam int CNT_W = 6;

  // Flush prefix: CR LF followed by the 18-byte tag
  localparam int PRE_LEN = 20;

  // Command codes from front to back
  localparam logic [1:0] OP_ECHO  = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // Return one byte of the flush prefix
  function automatic logic [7:0] pre_byte(input logic [4:0] i);
    logic [7:0] b;
    unique case (i)
      5'd0:    b = CH_CR;
      5'd1:    b = CH_LF;
      5'd2:    b = 8'h44;
      5'd3:    b = 8'h32;
      5'd4:    b = 8'h33;
      5'd5:    b = 8'h43;
      5'd6:    b = 8'h51;
      5'd7:    b = 8'h44;
      5'd8:    b = 8'h54;
      5'd9:    b = 8'h30;
      5'd10:   b = 8'h31;
      5'd11:   b = 8'h5F;
      5'd12:   b = 8'h4E;
      5'd13:   b = 8'h68;
      5'd14:   b = 8'h6F;
      5'd15:   b = 8'h6D;
      5'd16:   b = 8'h30;
      5'd17:   b = 8'h33;
      5'd18:   b = 8'h3A;
      5'd19:   b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- design/lew_rx_if.sv -----
`default_nettype none
interface lew_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- design/lew_tx_if.sv -----
`default_nettype none
interface lew_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface
`default_nettype wire

// ----- design/lew_ram.sv -----
`default_nettype none
module lew_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/lew_queue.sv -----
`default_nettype none
module lew_queue
  import lew_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      not_empty
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_cmd   = entry[rd_ptr];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && !full, pop && not_empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/lew_front.sv -----
`default_nettype none
module lew_front
  import lew_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lew_rx_if.sink                            rx,
  input  wire logic                         q_full,
  output logic                              q_push,
  output cmd_t                              q_cmd,
  input  wire logic                         flush_done,
  output logic                              we,
  output logic [$clog2(BUF_DEPTH)-1:0]      waddr,
  output logic [7:0]                        wdata
);

  localparam int CW = $clog2(BUF_DEPTH);

  logic          flush_busy;
  logic          flush_busy_next;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;
  logic          accept;

  // Hold off input while a flush still reads the line store or the command queue is full
  assign rx.ready = !flush_busy && !q_full;
  assign accept   = rx.valid && rx.ready;
  assign waddr    = fill_count;
  assign wdata    = rx.rx_byte;

  // Classify the item, issue a command when one is due and write stored characters
  always_comb begin
    fill_count_next = fill_count;
    flush_busy_next = flush_busy;
    q_push          = 1'b0;
    we              = 1'b0;
    q_cmd.op        = OP_ECHO;
    q_cmd.data      = rx.rx_byte;
    q_cmd.count     = CNT_W'(fill_count);
    if (flush_done) begin
      flush_busy_next = 1'b0;
    end
    if (accept) begin
      priority if (rx.rx_byte == CH_FLUSH) begin
        q_push          = 1'b1;
        q_cmd.op        = OP_FLUSH;
        fill_count_next = '0;
        flush_busy_next = 1'b1;
      end else if (rx.rx_byte == CH_BS) begin
        if (fill_count != '0) begin
          q_push          = 1'b1;
          q_cmd.op        = OP_ERASE;
          fill_count_next = fill_count - 1'b1;
        end
      end else if (rx.rx_byte == CH_CR || rx.rx_byte == CH_LF) begin
        // ignore line endings
      end else begin
        if (fill_count != CW'(BUF_DEPTH - 1)) begin
          q_push          = 1'b1;
          we              = 1'b1;
          fill_count_next = fill_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      flush_busy <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      flush_busy <= flush_busy_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/lew_back.sv -----
`default_nettype none
module lew_back
  import lew_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire cmd_t                         q_cmd,
  output logic                              q_pop,
  output logic                              flush_done,
  output logic                              re,
  output logic [$clog2(BUF_DEPTH)-1:0]      raddr,
  input  wire logic [7:0]                   rdata,
  lew_tx_if.source                          tx
);

  localparam int CW = $clog2(BUF_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ECHO  = 3'd1;
  localparam logic [2:0] ST_ERASE = 3'd2;
  localparam logic [2:0] ST_PRE   = 3'd3;
  localparam logic [2:0] ST_BODY  = 3'd4;
  localparam logic [2:0] ST_SUF   = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  cmd_t          cur;
  cmd_t          cur_next;
  logic [4:0]    step;
  logic [4:0]    step_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic          out_valid;
  logic          out_valid_next;
  logic [7:0]    out_byte;
  logic [7:0]    out_byte_next;
  logic          out_last;
  logic          out_last_next;
  logic          slot_free;
  logic          emit;

  assign slot_free  = !out_valid || tx.ready;
  assign tx.valid   = out_valid;
  assign tx.tx_byte = out_byte;
  assign tx.last    = out_last;

  // Sequence the bytes of each command
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    step_next     = step;
    idx_next      = idx;
    emit          = 1'b0;
    out_byte_next = out_byte;
    out_last_next = out_last;
    q_pop         = 1'b0;
    flush_done    = 1'b0;
    re            = 1'b0;
    raddr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_next  = q_cmd;
          step_next = '0;
          idx_next  = '0;
          unique case (q_cmd.op)
            OP_ECHO:  state_next = ST_ECHO;
            OP_ERASE: state_next = ST_ERASE;
            OP_FLUSH: state_next = ST_PRE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_byte_next = cur.data;
          out_last_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_ERASE: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_byte_next = (step == 5'd1) ? CH_SPACE : CH_BS;
          out_last_next = (step == 5'd2);
          step_next     = step + 5'd1;
          if (step == 5'd2) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRE: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_byte_next = pre_byte(step);
          out_last_next = 1'b0;
          step_next     = step + 5'd1;
          if (step == 5'(PRE_LEN - 1)) begin
            // prefetch the first stored character
            re         = 1'b1;
            raddr      = '0;
            state_next = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_last_next = 1'b0;
          if (CNT_W'(idx) == cur.count || rdata == 8'h00) begin
            out_byte_next = CH_CR;
            state_next    = ST_SUF;
          end else begin
            out_byte_next = rdata;
            idx_next      = idx + 1'b1;
            re            = 1'b1;
            raddr         = idx + 1'b1;
          end
        end
      end
      ST_SUF: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_byte_next = CH_LF;
          out_last_next = 1'b1;
          flush_done    = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = emit ? 1'b1 : (tx.ready ? 1'b0 : out_valid);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    step     <= step_next;
    idx      <= idx_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
  end

endmodule
`default_nettype wire

// ----- design/line_editor_with_echo_top.sv -----
`default_nettype none
// Line editor with echo: a front stage classifies received bytes, a back stage emits output.
// An accepted item passes the command queue, sequencer state and output register before output.
// Throughput: at most one output byte per cycle while tx.ready allows; new items are taken while
// earlier ones are still sent, but input is held off until a flush loads its last byte for output.
// Reset (rst, synchronous): clears fill count, command queue and sequencer; line store
// contents are not cleared.
module line_editor_with_echo_top
  import lew_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  lew_rx_if.sink    rx,
  lew_tx_if.source  tx
);

  localparam int CW = $clog2(BUF_DEPTH);

  cmd_t          push_cmd;
  cmd_t          pop_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic          flush_done;
  logic          we;
  logic [CW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [CW-1:0] raddr;
  logic [7:0]    rdata;

  lew_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .flush_done (flush_done),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata)
  );

  lew_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  lew_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  lew_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .flush_done (flush_done),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .tx         (tx)
  );

endmodule
`default_nettype wire

// ----- dv/line_echo_checker.sv -----
`default_nettype none
module line_echo_checker
  import lew_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  lew_rx_if         rx,
  lew_tx_if         tx,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } echo_byte_t;

  // Tag emitted after CR LF on every flush
  localparam logic [7:0] TAG_TEXT [18] = '{
    8'h44, 8'h32, 8'h33, 8'h43, 8'h51, 8'h44, 8'h54, 8'h30, 8'h31,
    8'h5F,
    8'h4E, 8'h68, 8'h6F, 8'h6D, 8'h30, 8'h33,
    8'h3A, 8'h20
  };

  logic [7:0] line_buf [LINE_DEPTH];
  logic [5:0] line_len;
  echo_byte_t tx_expected [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] line echo check: %s", $realtime, what);
    mismatches++;
  endtask

  // Work out the bytes one received item causes and queue them
  task automatic predict_output(input logic [7:0] c);
    logic [7:0] seq [$];
    int k;
    if (c == CH_FLUSH) begin
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
      for (k = 0; k < 18; k++) seq.push_back(TAG_TEXT[k]);
      // stop at the first stored zero
      for (k = 0; k < int'(line_len); k++) begin
        if (line_buf[k] == 8'h00) break;
        seq.push_back(line_buf[k]);
      end
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
      line_len = '0;
    end else if (c == CH_BS) begin
      if (line_len != 0) begin
        line_len = line_len - 6'd1;
        seq.push_back(CH_BS);
        seq.push_back(CH_SPACE);
        seq.push_back(CH_BS);
      end
    end else if (c != CH_CR && c != CH_LF) begin
      // drop silently when the line is full
      if (int'(line_len) < LINE_DEPTH - 1) begin
        line_buf[line_len] = c;
        line_len = line_len + 6'd1;
        seq.push_back(c);
      end
    end
    for (k = 0; k < seq.size(); k++)
      tx_expected.push_back('{tx_byte: seq[k], last: (k == seq.size() - 1)});
  endtask

  // Compare outgoing bytes first, then predict from the incoming item
  always @(posedge clk) begin : check_flow
    echo_byte_t want;
    if (rst) begin
      tx_expected.delete();
      line_len   = '0;
      mismatches = 0;
    end else begin
      if (tx.valid === 1'b1 && tx.ready === 1'b1) begin
        if (tx_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %b", tx.tx_byte, tx.last));
        end else begin
          want = tx_expected.pop_front();
          if (tx.tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, want %02h", tx.tx_byte, want.tx_byte));
          if (tx.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (byte %02h)", tx.last, want.last,
                                      want.tx_byte));
        end
      end
      if (rx.valid === 1'b1 && rx.ready === 1'b1) predict_output(rx.rx_byte);
    end
    pending <= tx_expected.size();
  end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench
  import lew_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 32;
  localparam int ITEM_TARGET = 350;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int unsigned tx_seen = 0;
  int unsigned fed;
  bit   rx_burst;

  lew_rx_if rx_link ();
  lew_tx_if tx_link ();

  line_editor_with_echo_top #(
    .BUF_DEPTH(LINE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_link),
    .tx (tx_link)
  );

  line_echo_checker #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_link),
    .tx        (tx_link),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (tx_link.valid === 1'b1 && tx_link.ready === 1'b1) tx_seen <= tx_seen + 1;
  end

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random byte that is no control code; zero is allowed unless nonzero is set
  function automatic logic [7:0] plain_char(input bit nonzero);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_FLUSH || c == CH_BS || c == CH_CR || c == CH_LF || (nonzero && c == 8'h00));
    return c;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = rx_burst ? 0 : pick_gap();
    if (gap != 0) begin
      rx_link.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_link.valid   <= 1'b1;
    rx_link.rx_byte <= b;
    do @(posedge clk); while (rx_link.ready !== 1'b1);
    if (b != CH_CR && b != CH_LF) fed++;
  endtask

  // Drop valid and wait for every expected byte
  task automatic drain_wait();
    rx_link.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random line content, optionally closed by a flush
  task automatic send_line(input int unsigned len, input bit flush_it);
    int unsigned k;
    int unsigned r;
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_byte(CH_BS);
      else if (r < 10) send_byte(CH_CR);
      else if (r < 12) send_byte(CH_LF);
      else if (r < 15) send_byte(8'h00);
      else if (r < 18) send_byte(8'($urandom_range(0, 255)));
      else send_byte(plain_char(1'b0));
    end
    if (flush_it) send_byte(CH_FLUSH);
  endtask

  // Receiver side: random stalls, steady stretches and long hold-offs
  initial begin : tx_drain
    int unsigned seg;
    int unsigned gap;
    int unsigned holds;
    bit steady;
    holds = 0;
    tx_link.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      steady = ($urandom_range(0, 3) == 0);
      seg = $urandom_range(10, 150);
      repeat (seg) begin
        if (holds < 2 && tx_seen >= 250 + 750 * holds) begin
          tx_link.ready <= 1'b0;
          repeat (400) @(posedge clk);
          holds++;
        end else begin
          gap = steady ? 0 : pick_gap();
          if (gap != 0) begin
            tx_link.ready <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        tx_link.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender side: directed items, then random lines
  initial begin : feed
    int unsigned lines;
    int unsigned r;
    int unsigned len;
    fed = 0;
    rx_burst = 1'b0;
    rx_link.valid   <= 1'b0;
    rx_link.rx_byte <= 8'h00;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // erase on empty line, ignored line ends, flush of an empty line
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_FLUSH);
    // extremes, stored zero cuts the flushed text short
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(CH_BS);
    send_byte(8'h80);
    send_byte(CH_FLUSH);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_FLUSH);
    send_byte(CH_BS);
    drain_wait();

    // overfill one line, then flush the longest message
    repeat (35) send_byte(plain_char(1'b1));
    send_byte(CH_FLUSH);

    lines = 0;
    while (fed < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (r < 60) len = $urandom_range(0, 12);
      else if (r < 85) len = $urandom_range(13, 30);
      else len = $urandom_range(31, 40);
      send_line(len, $urandom_range(0, 9) != 0);
      lines++;
      if (lines % 6 == 0) drain_wait();
    end
    rx_burst = 1'b0;
    send_byte(CH_FLUSH);
    drain_wait();
    repeat (12) @(posedge clk);

    if (mismatches == 0) begin
      $display("line_editor_with_echo_top: match");
    end else begin
      $display("line_editor_with_echo_top: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #20ms;
    $display("line_editor_with_echo_top: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
